### design/apvt_pkg.sv
// shared types, codes and widths for the aged peer view table
`timescale 1ns / 1ps

package apvt_pkg;

   // default table depth
   localparam int VIEW_SIZE_DEF = 8;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int ID_W       = 16;
   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int TIME_W     = 32;
   localparam int PICK_W     = 3;
   localparam int STAT_W     = 3;
   localparam int CNT_OUT_W  = 4;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 104;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UPSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_OLDEST = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_PICK   = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY_ID  = 3'd3;
   localparam logic [STAT_W-1:0] ST_TAKEN     = 3'd4;
   localparam logic [STAT_W-1:0] ST_NONE      = 3'd5;
   localparam logic [STAT_W-1:0] ST_BAD_PICK  = 3'd6;

   // what the datapath does with each entry read
   localparam logic [1:0] MODE_MATCH  = 2'd0;
   localparam logic [1:0] MODE_OLDEST = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;

   // one peer descriptor
   typedef struct packed {
      logic [TIME_W-1:0] tstamp;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   id;
   } entry_type;

   // request layout on tdata, last field in the lowest bits
   typedef struct packed {
      logic [2:0]        spare;
      logic [PICK_W-1:0] pick;
      logic [TIME_W-1:0] tstamp;
      logic [PORT_W-1:0] port;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   id;
      logic [FUNC_W-1:0] func;
   } req_type;

   // response layout on tdata, last field in the lowest bits
   typedef struct packed {
      logic                 spare;
      logic [CNT_OUT_W-1:0] count;
      logic [TIME_W-1:0]    tstamp;
      logic [PORT_W-1:0]    port;
      logic [ADDR_W-1:0]    addr;
      logic [ID_W-1:0]      id;
      logic [STAT_W-1:0]    status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       init_zero;
      logic       init_pick;
      logic       init_best;
      logic       issue;
      logic [1:0] mode;
      logic       finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              id_zero;
      logic              count_zero;
      logic              pick_bad;
      logic              iss_done;
      logic              out_free;
   } sts_type;

endpackage

### design/apvt_datapath.sv
// peer table memory, scan and shift datapath, result register
`timescale 1ns / 1ps

module apvt_datapath #(
   parameter int VIEW_SIZE = apvt_pkg::VIEW_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  apvt_pkg::cmd_type                 cmd,
   output apvt_pkg::sts_type                 sts,
   // func, node_id, node_addr, node_port, node_time, pick_index, zero pad
   input  logic [apvt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, out_node_id, out_node_addr, out_node_port, out_node_time,
   // entry_count, zero pad
   output logic [apvt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IW = (VIEW_SIZE > 1) ? $clog2(VIEW_SIZE) : 1;
   localparam int CW = $clog2(VIEW_SIZE + 1);
   localparam int WW = (CW > apvt_pkg::PICK_W) ? CW : apvt_pkg::PICK_W;
   localparam int XW = (CW > apvt_pkg::CNT_OUT_W) ? CW : apvt_pkg::CNT_OUT_W;

   apvt_pkg::entry_type mem [VIEW_SIZE];

   apvt_pkg::req_type   req_ff;
   logic [CW-1:0]       count_ff, count_in, count_fin;
   logic [CW-1:0]       iss_ff, iss_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic                rd_vld_ff;
   logic [IW-1:0]       rd_idx_ff;
   logic [1:0]          rd_mode_ff;
   apvt_pkg::entry_type rd_data_ff;
   logic                hit_ff;
   logic [IW-1:0]       hit_idx_ff;
   apvt_pkg::entry_type hit_entry_ff;
   logic [IW-1:0]       best_idx_ff;
   logic [apvt_pkg::TIME_W-1:0] best_time_ff;
   apvt_pkg::entry_type taken_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   apvt_pkg::rsp_type   rsp_ff;

   logic [WW-1:0]       pick_ext, count_ext;
   logic [XW-1:0]       count_wide;
   logic                full, sh_we;
   logic                fin_we;
   logic [IW-1:0]       fin_wa;
   apvt_pkg::entry_type fin_wd, fin_entry, new_entry;
   logic [apvt_pkg::STAT_W-1:0] fin_status;
   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   apvt_pkg::entry_type mem_wd;

   // status toward the controller
   assign pick_ext  = WW'(req_ff.pick);
   assign count_ext = WW'(count_ff);
   assign full      = (count_ff == CW'(VIEW_SIZE));

   assign sts.func       = req_ff.func;
   assign sts.full       = full;
   assign sts.id_zero    = (req_ff.id == '0);
   assign sts.count_zero = (count_ff == '0);
   assign sts.pick_bad   = (pick_ext >= count_ext);
   assign sts.iss_done   = (iss_ff >= count_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= apvt_pkg::req_type'(req_tdata);
      end
   end

   // read pointer and take position
   always_comb begin
      iss_in = iss_ff;
      pos_in = pos_ff;
      if (cmd.init_zero) begin
         iss_in = '0;
      end else if (cmd.init_pick) begin
         iss_in = pick_ext[CW-1:0];
         pos_in = pick_ext[IW-1:0];
      end else if (cmd.init_best) begin
         iss_in = CW'(best_idx_ff);
         pos_in = best_idx_ff;
      end else if (cmd.issue) begin
         iss_in = iss_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= '0;
         pos_ff <= '0;
      end else begin
         iss_ff <= iss_in;
         pos_ff <= pos_in;
      end
   end

   // registered table read, tagged with index and mode
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= mem[iss_ff[IW-1:0]];
         rd_idx_ff  <= iss_ff[IW-1:0];
         rd_mode_ff <= cmd.mode;
      end
   end

   // per-entry compare: id match, oldest timestamp, or take capture
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         hit_ff <= 1'b0;
      end else if (rd_vld_ff && rd_mode_ff == apvt_pkg::MODE_MATCH && !hit_ff
                   && rd_data_ff.id == req_ff.id) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         case (rd_mode_ff)
            apvt_pkg::MODE_MATCH: begin
               if (!hit_ff && rd_data_ff.id == req_ff.id) begin
                  hit_idx_ff   <= rd_idx_ff;
                  hit_entry_ff <= rd_data_ff;
               end
            end
            apvt_pkg::MODE_OLDEST: begin
               // strict less keeps the lowest position on ties
               if (rd_idx_ff == '0 || rd_data_ff.tstamp < best_time_ff) begin
                  best_idx_ff  <= rd_idx_ff;
                  best_time_ff <= rd_data_ff.tstamp;
               end
            end
            apvt_pkg::MODE_SHIFT: begin
               if (rd_idx_ff == pos_ff) begin
                  taken_ff <= rd_data_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // shift later entries down one place
   assign sh_we = rd_vld_ff && rd_mode_ff == apvt_pkg::MODE_SHIFT && rd_idx_ff != pos_ff;

   // outcome of the operation
   always_comb begin
      new_entry.id     = req_ff.id;
      new_entry.addr   = req_ff.addr;
      new_entry.port   = req_ff.port;
      new_entry.tstamp = req_ff.tstamp;
      fin_we     = 1'b0;
      fin_wa     = count_ff[IW-1:0];
      fin_wd     = new_entry;
      fin_entry  = '0;
      fin_status = apvt_pkg::ST_ADDED;
      count_fin  = count_ff;
      case (req_ff.func)
         apvt_pkg::FUNC_ADD, apvt_pkg::FUNC_UPSERT: begin
            if (req_ff.func == apvt_pkg::FUNC_ADD && full) begin
               fin_status = apvt_pkg::ST_FULL;
            end else if (sts.id_zero) begin
               fin_status = apvt_pkg::ST_EMPTY_ID;
            end else if (hit_ff) begin
               fin_we        = 1'b1;
               fin_wa        = hit_idx_ff;
               fin_wd        = hit_entry_ff;
               fin_wd.tstamp = req_ff.tstamp;
               fin_status    = apvt_pkg::ST_REFRESHED;
            end else if (!full) begin
               fin_we     = 1'b1;
               fin_status = apvt_pkg::ST_ADDED;
               count_fin  = count_ff + 1'b1;
            end else begin
               fin_status = apvt_pkg::ST_FULL;
            end
         end
         default: begin
            if (sts.count_zero) begin
               fin_status = apvt_pkg::ST_NONE;
            end else if (req_ff.func == apvt_pkg::FUNC_PICK && sts.pick_bad) begin
               fin_status = apvt_pkg::ST_BAD_PICK;
            end else begin
               fin_status = apvt_pkg::ST_TAKEN;
               fin_entry  = taken_ff;
               count_fin  = count_ff - 1'b1;
            end
         end
      endcase
   end

   // table write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = fin_wa;
      mem_wd = fin_wd;
      if (sh_we) begin
         mem_we = 1'b1;
         mem_wa = rd_idx_ff - 1'b1;
         mem_wd = rd_data_ff;
      end else if (cmd.finish && fin_we) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   // entry count
   assign count_in = cmd.finish ? count_fin : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   assign count_wide   = XW'(count_fin);
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.spare  <= 1'b0;
         rsp_ff.count  <= count_wide[apvt_pkg::CNT_OUT_W-1:0];
         rsp_ff.tstamp <= fin_entry.tstamp;
         rsp_ff.port   <= fin_entry.port;
         rsp_ff.addr   <= fin_entry.addr;
         rsp_ff.id     <= fin_entry.id;
         rsp_ff.status <= fin_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // checks
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> iss_ff < count_ff)
      else $error("table read issued at or beyond entry count");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      sh_we |-> (rd_idx_ff != '0) && (CW'(rd_idx_ff) < count_ff))
      else $error("shift write outside the valid entries");

   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a pending response");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.finish |=> $stable(count_ff))
      else $error("entry count changed outside finish");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(VIEW_SIZE))
      else $error("entry count above table depth");

endmodule

### design/apvt_ctrl.sv
// sequencing state machine for the aged peer view table
`timescale 1ns / 1ps

module apvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  apvt_pkg::sts_type sts,
   output apvt_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SETUP  = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mode   = apvt_pkg::MODE_MATCH;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (sts.func)
               apvt_pkg::FUNC_ADD, apvt_pkg::FUNC_UPSERT: begin
                  if ((sts.func == apvt_pkg::FUNC_ADD && sts.full) || sts.id_zero
                      || sts.count_zero) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.init_zero = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               apvt_pkg::FUNC_OLDEST: begin
                  if (sts.count_zero) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.init_zero = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
                  if (sts.count_zero || sts.pick_bad) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.init_pick = 1'b1;
                     state_in      = S_SHIFT;
                  end
               end
            endcase
         end
         S_SCAN: begin
            cmd.mode = (sts.func == apvt_pkg::FUNC_OLDEST) ? apvt_pkg::MODE_OLDEST
                                                           : apvt_pkg::MODE_MATCH;
            if (!sts.iss_done) begin
               cmd.issue = 1'b1;
            end else if (sts.func == apvt_pkg::FUNC_OLDEST) begin
               state_in = S_SETUP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SETUP: begin
            // last compare has landed, start the shift at the oldest entry
            cmd.init_best = 1'b1;
            state_in      = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.mode = apvt_pkg::MODE_SHIFT;
            if (!sts.iss_done) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/aged_peer_view_table.sv
// top level of the aged peer view table
//
//   channel   direction  tdata fields (lowest bit up)
//   req_      in         func, node_id, node_addr, node_port, node_time, pick_index
//   rsp_      out        status, out_node_id, out_node_addr, out_node_port,
//                        out_node_time, entry_count
//
// one request at a time; add and upsert scan every entry for a matching id, take oldest
// scans every entry for the oldest timestamp and then shifts the later entries down,
// take at pick shifts the entries after the pick down, and a request rejected at once
// or added to an empty table skips the scan; the single table read port steps one entry
// a cycle through the scan and the shift
// reset clears the entry count and the control state; the table needs no clearing
// a finished response waits in its output register while the next request is taken;
// a request whose result is ready holds in its last step until that register frees
`timescale 1ns / 1ps

module aged_peer_view_table #(
   parameter int VIEW_SIZE = apvt_pkg::VIEW_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // func, node_id, node_addr, node_port, node_time, pick_index, zero pad
   input  logic [apvt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, out_node_id, out_node_addr, out_node_port, out_node_time,
   // entry_count, zero pad
   output logic [apvt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   apvt_pkg::cmd_type cmd;
   apvt_pkg::sts_type sts;

   // sequencer
   apvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table and result path
   apvt_datapath #(
      .VIEW_SIZE (VIEW_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/sv/aged_peer_view_table_test.sv
// self-checking testbench for the aged peer view table: directed and random requests
`timescale 1ns / 1ps

module aged_peer_view_table_test;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 700;
   localparam int POOL_SIZE    = 12;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [apvt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [apvt_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // idling control: steady is shared by both sides, the hold pauses the response side
   bit steady     = 1'b0;
   bit hold_start = 1'b0;
   int hold_left  = 0;

   // predicts the table and checks responses in order
   class peer_view_scoreboard;
      apvt_pkg::entry_type view[apvt_pkg::VIEW_SIZE_DEF];
      int unsigned         used;
      apvt_pkg::rsp_type   expected_q[$];
      int                  errors;
      int                  requests;
      int                  status_seen[8];

      function new();
         used     = 0;
         errors   = 0;
         requests = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      // remove one entry and close the gap
      function void take_entry(int unsigned pos, inout apvt_pkg::rsp_type e);
         int unsigned i;
         e.status = apvt_pkg::ST_TAKEN;
         e.id     = view[pos].id;
         e.addr   = view[pos].addr;
         e.port   = view[pos].port;
         e.tstamp = view[pos].tstamp;
         for (i = pos; i + 1 < used; i++) view[i] = view[i + 1];
         used--;
      endfunction

      // work out the response to one accepted request
      function void note_request(apvt_pkg::req_type r);
         apvt_pkg::rsp_type e;
         int                hit;
         int unsigned       i;
         int unsigned       best;
         e   = '0;
         hit = -1;
         requests++;
         if (r.func == apvt_pkg::FUNC_ADD || r.func == apvt_pkg::FUNC_UPSERT) begin
            if (r.func == apvt_pkg::FUNC_ADD && used >= apvt_pkg::VIEW_SIZE_DEF) begin
               e.status = apvt_pkg::ST_FULL;
            end else if (r.id == '0) begin
               e.status = apvt_pkg::ST_EMPTY_ID;
            end else begin
               for (i = 0; i < used; i++)
                  if (hit < 0 && view[i].id == r.id) hit = i;
               if (hit >= 0) begin
                  // refresh keeps address and port
                  view[hit].tstamp = r.tstamp;
                  e.status = apvt_pkg::ST_REFRESHED;
               end else if (used < apvt_pkg::VIEW_SIZE_DEF) begin
                  view[used].id     = r.id;
                  view[used].addr   = r.addr;
                  view[used].port   = r.port;
                  view[used].tstamp = r.tstamp;
                  used++;
                  e.status = apvt_pkg::ST_ADDED;
               end else begin
                  e.status = apvt_pkg::ST_FULL;
               end
            end
         end else if (used == 0) begin
            e.status = apvt_pkg::ST_NONE;
         end else if (r.func == apvt_pkg::FUNC_OLDEST) begin
            // first smallest timestamp wins
            best = 0;
            for (i = 1; i < used; i++)
               if (view[i].tstamp < view[best].tstamp) best = i;
            take_entry(best, e);
         end else if (r.pick >= used) begin
            e.status = apvt_pkg::ST_BAD_PICK;
         end else begin
            take_entry(r.pick, e);
         end
         e.count = used[apvt_pkg::CNT_OUT_W-1:0];
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // compare one response with the oldest prediction
      function void check_response(apvt_pkg::rsp_type got);
         apvt_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = expected_q.pop_front();
         status_seen[want.status]++;
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("node id", 32'(want.id), 32'(got.id));
         compare_field("node addr", want.addr, got.addr);
         compare_field("node port", 32'(want.port), 32'(got.port));
         compare_field("node time", want.tstamp, got.tstamp);
         compare_field("entry count", 32'(want.count), 32'(got.count));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   peer_view_scoreboard board = new();

   aged_peer_view_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: check, then pick the next ready level
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) board.check_response(apvt_pkg::rsp_type'(rsp_tdata));
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 6);
      end
   end

   // overall cycle limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   function automatic apvt_pkg::req_type peer_request(
         logic [apvt_pkg::FUNC_W-1:0] f, logic [apvt_pkg::ID_W-1:0] id,
         logic [apvt_pkg::ADDR_W-1:0] a, logic [apvt_pkg::PORT_W-1:0] p,
         logic [apvt_pkg::TIME_W-1:0] t, logic [apvt_pkg::PICK_W-1:0] k);
      apvt_pkg::req_type r;
      r        = '0;
      r.func   = f;
      r.id     = id;
      r.addr   = a;
      r.port   = p;
      r.tstamp = t;
      r.pick   = k;
      return r;
   endfunction

   // offer one request, with an occasional gap first
   task automatic send_request(input apvt_pkg::req_type r);
      while (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
   endtask

   // stimulus and end of run
   initial begin
      logic [apvt_pkg::ID_W-1:0] id_pool[POOL_SIZE];
      apvt_pkg::req_type         r;
      int                        n;
      int                        roll;
      int unsigned               fill;

      foreach (id_pool[k]) id_pool[k] = 16'($urandom_range(65535, 1));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, empty ids, extremes, ties, full table, picks
      send_request(peer_request(apvt_pkg::FUNC_OLDEST, 16'd0, 32'd0, 16'd0, 32'd0, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_PICK, 16'd0, 32'd0, 16'd0, 32'd0, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_ADD, 16'd0, 32'hFFFF_FFFF, 16'hFFFF,
                                32'd1, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_UPSERT, 16'd0, 32'd1, 16'd1, 32'd1, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                32'hFFFF_FFFF, 3'd7));
      send_request(peer_request(apvt_pkg::FUNC_ADD, 16'd1, 32'd0, 16'd0, 32'd0, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_ADD, 16'hFFFF, 32'h1234_5678, 16'h55AA,
                                32'd5, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_UPSERT, 16'd1, 32'hAAAA_AAAA, 16'hAAAA,
                                32'd5, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_OLDEST, 16'd0, 32'd0, 16'd0, 32'd0, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_PICK, 16'd0, 32'd0, 16'd0, 32'd0, 3'd1));
      send_request(peer_request(apvt_pkg::FUNC_PICK, 16'd0, 32'd0, 16'd0, 32'd0, 3'd7));
      for (n = 2; n <= 8; n++)
         send_request(peer_request(apvt_pkg::FUNC_UPSERT, n[15:0], $urandom,
                                   16'($urandom), 32'd100 - n, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_ADD, 16'd9, 32'd9, 16'd9, 32'd9, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_ADD, 16'd0, 32'd9, 16'd9, 32'd9, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_UPSERT, 16'd9, 32'd9, 16'd9, 32'd9, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_UPSERT, 16'd0, 32'd9, 16'd9, 32'd9, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_UPSERT, 16'd3, 32'd0, 16'd0,
                                32'hFFFF_FFFF, 3'd0));
      send_request(peer_request(apvt_pkg::FUNC_PICK, 16'd0, 32'd0, 16'd0, 32'd0, 3'd7));
      send_request(peer_request(apvt_pkg::FUNC_PICK, 16'd0, 32'd0, 16'd0, 32'd0, 3'd0));

      // random: pooled ids for refreshes, small timestamps for ties
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100 || n == 500) hold_start = 1'b1;
         if (n == 250) steady = 1'b1;
         if (n == 400) steady = 1'b0;
         fill = board.used;
         roll = $urandom_range(99);
         if (fill < 2) roll = roll / 2;
         r        = '0;
         r.func   = roll < 30 ? apvt_pkg::FUNC_ADD : roll < 55 ? apvt_pkg::FUNC_UPSERT :
                    roll < 75 ? apvt_pkg::FUNC_OLDEST : apvt_pkg::FUNC_PICK;
         r.addr   = $urandom;
         r.port   = 16'($urandom);
         r.tstamp = $urandom_range(1) ? $urandom_range(7) : $urandom;
         roll     = $urandom_range(99);
         r.id     = roll < 5 ? 16'd0 : roll < 15 ? 16'($urandom) :
                    id_pool[$urandom_range(POOL_SIZE - 1)];
         if (fill > 0 && $urandom_range(99) < 85) r.pick = 3'($urandom_range(fill - 1));
         else r.pick = 3'($urandom_range(7));
         send_request(r);
      end
      req_tvalid <= 1'b0;

      // drain, then allow time for any stray response
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d added, %0d refreshed, %0d full, %0d empty id",
               board.requests, board.status_seen[apvt_pkg::ST_ADDED],
               board.status_seen[apvt_pkg::ST_REFRESHED],
               board.status_seen[apvt_pkg::ST_FULL],
               board.status_seen[apvt_pkg::ST_EMPTY_ID]);
      $display("  %0d taken, %0d on empty table, %0d bad picks, %0d mismatches",
               board.status_seen[apvt_pkg::ST_TAKEN], board.status_seen[apvt_pkg::ST_NONE],
               board.status_seen[apvt_pkg::ST_BAD_PICK], board.errors);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
